FILE: rtl/cfa_pkg.sv
`default_nettype none
package cfa_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE_ID = 2'd1;
	localparam logic [1:0] OP_FREE_OWNER = 2'd2;
	localparam logic [1:0] OP_COMPACT = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_WORST_ALT = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE = 3'd1;
	localparam logic [2:0] ST_OWNER_EXISTS = 3'd2;
	localparam logic [2:0] ST_NO_FIT = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL = 3'd5;

	localparam logic [1:0] REG_MEM_SIZE = 2'd0;

	localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] owner;
		logic [15:0] request_size;
		logic [1:0] fit_policy;
		logic [15:0] target_block;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] address;
		logic [15:0] granted_block;
		logic [15:0] total_free;
		logic [15:0] largest_free;
		logic [4:0] free_blocks;
		logic [15:0] internal_waste;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/contiguous_fit_allocator.sv
`default_nettype none
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | cfa_pkg::req_t
// out     | out | out_valid / out_ready| cfa_pkg::rsp_t
// cfg     | in  | APB psel/penable     | memory_size at 0x0
// An item is handled step by step from transfer in to result: a single state machine
// walks the table one entry per cycle, unless a memory_size write holds it, for
// owner check, search, shift (insert/erase/compact) and stats.
// Reset and a memory_size write give one free block [0, memory_size), id 1.
// in_ready is low from acceptance until the result is transferred.
module contiguous_fit_allocator #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cfa_pkg::req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output cfa_pkg::rsp_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	typedef enum logic [3:0] {
		S_IDLE, S_OWN, S_FIT, S_DEC, S_SHIFT, S_REL, S_MERGE, S_ERASE,
		S_CMP, S_TAIL, S_STAT, S_OUT
	} st_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] start;
		logic [SIZE_BITS-1:0] len;
		logic fr;
		logic [7:0] own;
		logic [SIZE_BITS-1:0] req;
		logic [15:0] id;
	} ent_t;

	ent_t tab_q [MAX_BLOCKS];
	logic [CW-1:0] cnt_q;
	logic [15:0] nid_q;
	logic [SIZE_BITS-1:0] msz_q;
	st_t st_q;
	cfa_pkg::req_t rq_q;
	logic [CW-1:0] i_q, n_q, pick_q, er_q;
	logic found_q, merged_q;
	logic [SIZE_BITS:0] pos_q;
	logic [SIZE_BITS-1:0] tot_q, big_q, waste_q;
	logic [4:0] nfree_q;
	logic [2:0] status_q;
	logic [15:0] addr_q, gid_q;

	logic cfg_wr;
	ent_t cur, nb, mv;
	logic [SIZE_BITS-1:0] rsz;
	logic better;

	assign pready = 1'b1;
	assign prdata = (paddr == cfa_pkg::REG_MEM_SIZE) ? 32'(msz_q) : 32'd0;
	assign cfg_wr = psel && penable && pwrite && (paddr == cfa_pkg::REG_MEM_SIZE);
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign rsz = SIZE_BITS'(rq_q.request_size);
	assign cur = tab_q[i_q[IW-1:0]];
	assign nb = tab_q[IW'(i_q + CW'(1))];

	always_comb begin
		mv = cur;
		mv.start = SIZE_BITS'(pos_q);
	end

	always_comb begin
		better = 1'b0;
		if (!found_q)
			better = 1'b1;
		else if (rq_q.fit_policy == cfa_pkg::FIT_BEST)
			better = cur.len < tab_q[pick_q[IW-1:0]].len;
		else
			better = cur.len > tab_q[pick_q[IW-1:0]].len;
	end

	always_comb begin
		out_data.status = status_q;
		out_data.address = addr_q;
		out_data.granted_block = gid_q;
		out_data.total_free = 16'(tot_q);
		out_data.largest_free = 16'(big_q);
		out_data.free_blocks = nfree_q;
		out_data.internal_waste = 16'(waste_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= CW'(1);
			nid_q <= 16'd2;
			msz_q <= SIZE_BITS'(cfa_pkg::MEM_SIZE_RESET);
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				tab_q[k].start <= '0;
				tab_q[k].len <= (k == 0) ? SIZE_BITS'(cfa_pkg::MEM_SIZE_RESET) : '0;
				tab_q[k].fr <= (k == 0);
				tab_q[k].req <= '0;
				tab_q[k].id <= (k == 0) ? 16'd1 : 16'd0;
			end
		end else if (cfg_wr) begin
			msz_q <= SIZE_BITS'(pwdata[15:0]);
			cnt_q <= CW'(1);
			nid_q <= 16'd2;
			tab_q[0].start <= '0;
			tab_q[0].len <= SIZE_BITS'(pwdata[15:0]);
			tab_q[0].fr <= 1'b1;
			tab_q[0].req <= '0;
			tab_q[0].id <= 16'd1;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						rq_q <= in_data;
						i_q <= '0;
						n_q <= '0;
						pos_q <= '0;
						found_q <= 1'b0;
						status_q <= cfa_pkg::ST_OK;
						addr_q <= '0;
						gid_q <= '0;
						case (in_data.opcode)
							cfa_pkg::OP_ALLOC: begin
								if (in_data.request_size == 16'd0 ||
									SIZE_BITS'(in_data.request_size) == '0) begin
									status_q <= cfa_pkg::ST_BAD_SIZE;
									st_q <= S_STAT;
								end else
									st_q <= S_OWN;
							end
							cfa_pkg::OP_COMPACT: st_q <= S_CMP;
							default: begin
								status_q <= cfa_pkg::ST_NOT_FOUND;
								st_q <= S_REL;
							end
						endcase
					end
				end
				S_OWN: begin
					if (i_q >= cnt_q) begin
						i_q <= '0;
						st_q <= S_FIT;
					end else if (!cur.fr && cur.own == rq_q.owner) begin
						status_q <= cfa_pkg::ST_OWNER_EXISTS;
						i_q <= '0;
						st_q <= S_STAT;
					end else
						i_q <= i_q + CW'(1);
				end
				S_FIT: begin
					if (i_q >= cnt_q)
						st_q <= S_DEC;
					else begin
						if (cur.fr && cur.len >= rsz && better) begin
							pick_q <= i_q;
							found_q <= 1'b1;
						end
						if (cur.fr && cur.len >= rsz &&
							rq_q.fit_policy == cfa_pkg::FIT_FIRST)
							st_q <= S_DEC;
						else
							i_q <= i_q + CW'(1);
					end
				end
				S_DEC: begin
					if (!found_q) begin
						status_q <= cfa_pkg::ST_NO_FIT;
						i_q <= '0;
						st_q <= S_STAT;
					end else if (tab_q[pick_q[IW-1:0]].len > rsz) begin
						if (cnt_q >= MAXC) begin
							status_q <= cfa_pkg::ST_TABLE_FULL;
							i_q <= '0;
							st_q <= S_STAT;
						end else begin
							i_q <= cnt_q;
							st_q <= S_SHIFT;
						end
					end else begin
						tab_q[pick_q[IW-1:0]].fr <= 1'b0;
						tab_q[pick_q[IW-1:0]].own <= rq_q.owner;
						tab_q[pick_q[IW-1:0]].req <= rsz;
						addr_q <= 16'(tab_q[pick_q[IW-1:0]].start);
						gid_q <= tab_q[pick_q[IW-1:0]].id;
						i_q <= '0;
						st_q <= S_STAT;
					end
				end
				S_SHIFT: begin
					if (i_q > pick_q + CW'(1)) begin
						tab_q[i_q[IW-1:0]] <= tab_q[IW'(i_q - CW'(1))];
						i_q <= i_q - CW'(1);
					end else begin
						tab_q[i_q[IW-1:0]].start <= tab_q[pick_q[IW-1:0]].start + rsz;
						tab_q[i_q[IW-1:0]].len <= tab_q[pick_q[IW-1:0]].len - rsz;
						tab_q[i_q[IW-1:0]].fr <= 1'b1;
						tab_q[i_q[IW-1:0]].own <= '0;
						tab_q[i_q[IW-1:0]].req <= '0;
						tab_q[i_q[IW-1:0]].id <= nid_q;
						nid_q <= nid_q + 16'd1;
						cnt_q <= cnt_q + CW'(1);
						tab_q[pick_q[IW-1:0]].len <= rsz;
						tab_q[pick_q[IW-1:0]].fr <= 1'b0;
						tab_q[pick_q[IW-1:0]].own <= rq_q.owner;
						tab_q[pick_q[IW-1:0]].req <= rsz;
						addr_q <= 16'(tab_q[pick_q[IW-1:0]].start);
						gid_q <= tab_q[pick_q[IW-1:0]].id;
						i_q <= '0;
						st_q <= S_STAT;
					end
				end
				S_REL: begin
					if (i_q >= cnt_q) begin
						i_q <= '0;
						st_q <= S_STAT;
					end else if (rq_q.opcode == cfa_pkg::OP_FREE_ID &&
						cur.id == rq_q.target_block) begin
						if (!cur.fr) begin
							status_q <= cfa_pkg::ST_OK;
							tab_q[i_q[IW-1:0]].fr <= 1'b1;
							tab_q[i_q[IW-1:0]].own <= '0;
							tab_q[i_q[IW-1:0]].req <= '0;
							merged_q <= 1'b0;
							st_q <= S_MERGE;
						end else begin
							i_q <= '0;
							st_q <= S_STAT;
						end
					end else if (rq_q.opcode == cfa_pkg::OP_FREE_OWNER && !cur.fr &&
						cur.own == rq_q.owner) begin
						status_q <= cfa_pkg::ST_OK;
						tab_q[i_q[IW-1:0]].fr <= 1'b1;
						tab_q[i_q[IW-1:0]].own <= '0;
						tab_q[i_q[IW-1:0]].req <= '0;
						merged_q <= 1'b0;
						st_q <= S_MERGE;
					end else
						i_q <= i_q + CW'(1);
				end
				S_MERGE: begin
					// merged_q=0: try left; =1: try right
					if (!merged_q) begin
						merged_q <= 1'b1;
						if (i_q != '0 && tab_q[IW'(i_q - CW'(1))].fr) begin
							tab_q[IW'(i_q - CW'(1))].len <=
								tab_q[IW'(i_q - CW'(1))].len + cur.len;
							er_q <= i_q;
							i_q <= i_q - CW'(1);
							pick_q <= '0;
							st_q <= S_ERASE;
						end
					end else begin
						if (i_q + CW'(1) < cnt_q && nb.fr) begin
							tab_q[i_q[IW-1:0]].len <= cur.len + nb.len;
							er_q <= i_q + CW'(1);
							merged_q <= 1'b0;
							pick_q <= '1;
							st_q <= S_ERASE;
						end else begin
							i_q <= '0;
							st_q <= S_STAT;
						end
					end
				end
				S_ERASE: begin
					if (er_q + CW'(1) < cnt_q) begin
						tab_q[er_q[IW-1:0]] <= tab_q[IW'(er_q + CW'(1))];
						er_q <= er_q + CW'(1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
						if (pick_q == '1) begin
							i_q <= '0;
							st_q <= S_STAT;
						end else
							st_q <= S_MERGE;
					end
				end
				S_CMP: begin
					if (i_q >= cnt_q) begin
						cnt_q <= n_q;
						st_q <= S_TAIL;
					end else begin
						if (!cur.fr) begin
							tab_q[n_q[IW-1:0]] <= mv;
							pos_q <= pos_q + {1'b0, cur.len};
							n_q <= n_q + CW'(1);
						end
						i_q <= i_q + CW'(1);
					end
				end
				S_TAIL: begin
					if ({1'b0, msz_q} > pos_q && n_q < MAXC) begin
						tab_q[n_q[IW-1:0]].start <= SIZE_BITS'(pos_q);
						tab_q[n_q[IW-1:0]].len <= SIZE_BITS'({1'b0, msz_q} - pos_q);
						tab_q[n_q[IW-1:0]].fr <= 1'b1;
						tab_q[n_q[IW-1:0]].own <= '0;
						tab_q[n_q[IW-1:0]].req <= '0;
						tab_q[n_q[IW-1:0]].id <= nid_q;
						nid_q <= nid_q + 16'd1;
						cnt_q <= n_q + CW'(1);
					end
					i_q <= '0;
					st_q <= S_STAT;
				end
				S_STAT: begin
					if (i_q == '0) begin
						tot_q <= '0;
						big_q <= '0;
						nfree_q <= '0;
						waste_q <= '0;
						i_q <= CW'(1);
					end else if (i_q > cnt_q)
						st_q <= S_OUT;
					else begin
						if (tab_q[IW'(i_q - CW'(1))].fr) begin
							tot_q <= tot_q + tab_q[IW'(i_q - CW'(1))].len;
							if (tab_q[IW'(i_q - CW'(1))].len > big_q)
								big_q <= tab_q[IW'(i_q - CW'(1))].len;
							nfree_q <= nfree_q + 5'd1;
						end else if (tab_q[IW'(i_q - CW'(1))].req != '0)
							waste_q <= waste_q + tab_q[IW'(i_q - CW'(1))].len -
								tab_q[IW'(i_q - CW'(1))].req;
						i_q <= i_q + CW'(1);
					end
				end
				S_OUT: begin
					if (out_ready)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
